### rtl/amre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amre_pkg
// Shared types, constants and helpers for the alpha mask run extractor.
// ----------------------------------------------------------------------------
package amre_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int ALPHA_W = 8;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    typedef enum logic [IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_LEFT      = 3'd1,
        REG_RIGHT     = 3'd2,
        REG_TOP       = 3'd3,
        REG_BOTTOM    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [ALPHA_W-1:0] threshold;
        logic [DIM_W-1:0]   left;
        logic [DIM_W-1:0]   right;
        logic [DIM_W-1:0]   top;
        logic [DIM_W-1:0]   bottom;
    } t_scan_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [DIM_W-1:0]   right;
        logic [COORD_W-1:0] row;
    } t_run;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_MAX) ? DIM_MAX : v;
    endfunction

endpackage
`default_nettype wire

### rtl/alpha_mask_run_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_mask_run_extractor
// Turns a raster stream of alpha bytes into opaque horizontal runs.
// ----------------------------------------------------------------------------
// One pixel is taken every clock cycle while o_in_stall is low. A pixel passes an
// input register and then the compare and counter logic, so a run is written to
// the result register when the pixel that ends it leaves the input register. The result
// register only holds back the stream while it is full and stalled. Writing a rectangle
// register restarts the scan at the top left corner; write configuration only
// while no pixel is in flight.
module alpha_mask_run_extractor
    import amre_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [ALPHA_W-1:0] i_alpha,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [COORD_W-1:0]      o_run_left,
    output logic [DIM_W-1:0]        o_run_right,
    output logic [COORD_W-1:0]      o_run_row
);

    logic [ALPHA_W-1:0] r_threshold;
    logic [DIM_W-1:0]   r_left;
    logic [DIM_W-1:0]   r_right;
    logic [DIM_W-1:0]   r_top;
    logic [DIM_W-1:0]   r_bottom;

    logic               r_in_valid;
    logic [ALPHA_W-1:0] r_alpha;
    logic               r_out_valid;
    t_run               r_run;

    t_reg_idx           reg_idx;
    logic               cfg_write;
    logic               rect_write;
    t_scan_cfg          scan_cfg;
    logic               out_free;
    logic               step;
    logic               in_take;
    logic               emit;
    t_run               run;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        rect_write = 1'b0;
        prdata     = '0;
        case (reg_idx)
            REG_THRESHOLD: prdata = DATA_W'(r_threshold);
            REG_LEFT: begin
                prdata     = DATA_W'(r_left);
                rect_write = cfg_write;
            end
            REG_RIGHT: begin
                prdata     = DATA_W'(r_right);
                rect_write = cfg_write;
            end
            REG_TOP: begin
                prdata     = DATA_W'(r_top);
                rect_write = cfg_write;
            end
            REG_BOTTOM: begin
                prdata     = DATA_W'(r_bottom);
                rect_write = cfg_write;
            end
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_left      <= '0;
            r_right     <= DIM_MAX;
            r_top       <= '0;
            r_bottom    <= DIM_MAX;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_THRESHOLD: r_threshold <= pwdata[ALPHA_W-1:0];
                REG_LEFT:      r_left      <= pwdata[DIM_W-1:0];
                REG_RIGHT:     r_right     <= pwdata[DIM_W-1:0];
                REG_TOP:       r_top       <= pwdata[DIM_W-1:0];
                REG_BOTTOM:    r_bottom    <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign scan_cfg.threshold = r_threshold;
    assign scan_cfg.left      = clamp_dim(r_left);
    assign scan_cfg.right     = clamp_dim(r_right);
    assign scan_cfg.top       = clamp_dim(r_top);
    assign scan_cfg.bottom    = clamp_dim(r_bottom);

    // pipeline handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_alpha <= i_alpha;
        end
    end

    amre_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (rect_write),
        .i_step    (step),
        .i_alpha   (r_alpha),
        .i_cfg     (scan_cfg),
        .o_emit    (emit),
        .o_run     (run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_run <= run;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_run_left  = r_run.left;
    assign o_run_right = r_run.right;
    assign o_run_row   = r_run.row;

    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_right > {1'b0, o_run_left}))
        else $error("run with end column not past start column");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_run)))
        else $error("stalled result lost or changed");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_no_step_while_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !emit)
        else $error("run produced while result register blocked");

endmodule
`default_nettype wire

### rtl/amre_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amre_scan
// Scan position and open-run tracking; one pixel per step, at most one run out.
// ----------------------------------------------------------------------------
module amre_scan
    import amre_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_restart,
    input  wire logic               i_step,
    input  wire logic [ALPHA_W-1:0] i_alpha,
    input  wire t_scan_cfg          i_cfg,
    output logic                    o_emit,
    output t_run                    o_run
);

    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic             r_open, n_open;
    logic [DIM_W-1:0] r_start, n_start;

    logic             empty_rect;
    logic             outside;
    logic [DIM_W-1:0] cur_col;
    logic [DIM_W-1:0] cur_row;
    logic             cur_open;
    logic [DIM_W-1:0] cur_start;
    logic             transparent;
    logic             close_run;
    logic             open_after;
    logic [DIM_W-1:0] start_after;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             row_end;

    assign empty_rect = (i_cfg.left >= i_cfg.right) || (i_cfg.top >= i_cfg.bottom);
    assign outside    = (r_col < i_cfg.left) || (r_col >= i_cfg.right)
                     || (r_row < i_cfg.top) || (r_row >= i_cfg.bottom);

    assign cur_col   = outside ? i_cfg.left : r_col;
    assign cur_row   = outside ? i_cfg.top  : r_row;
    assign cur_open  = outside ? 1'b0 : r_open;
    assign cur_start = outside ? '0   : r_start;

    assign transparent = (i_alpha <= i_cfg.threshold);
    assign close_run   = cur_open && transparent;
    assign open_after  = !transparent;
    assign start_after = (!cur_open && !transparent) ? cur_col : cur_start;

    assign col_inc = cur_col + 1'b1;
    assign row_inc = cur_row + 1'b1;
    assign row_end = (col_inc >= i_cfg.right);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_open  = r_open;
        n_start = r_start;
        o_emit  = 1'b0;
        o_run.left  = start_after[COORD_W-1:0];
        o_run.right = close_run ? cur_col : i_cfg.right;
        o_run.row   = cur_row[COORD_W-1:0];
        if (i_restart) begin
            // park outside any rectangle so the next pixel starts from the new edges
            n_col   = DIM_MAX;
            n_row   = DIM_MAX;
            n_open  = 1'b0;
            n_start = '0;
        end else if (i_step && !empty_rect) begin
            n_start = start_after;
            o_emit  = close_run || (row_end && open_after);
            if (row_end) begin
                n_col  = i_cfg.left;
                n_row  = (row_inc >= i_cfg.bottom) ? i_cfg.top : row_inc;
                n_open = 1'b0;
            end else begin
                n_col  = col_inc;
                n_row  = cur_row;
                n_open = open_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_open  <= 1'b0;
            r_start <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_open  <= n_open;
            r_start <= n_start;
        end
    end

endmodule
`default_nettype wire
